// ===== rtl/core/sfd_pkg.sv =====
package sfd_pkg;

  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 16;

  localparam logic [15:0] HelloTimeoutRst   = 16'd5000;
  localparam logic [15:0] PartialTimeoutRst = 16'd100;

  localparam logic [7:0] HeaderB0 = 8'h80;
  localparam logic [7:0] HeaderB1 = 8'h81;
  localparam logic [3:0] HelloLen = 4'd11;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHelloTimeout   = 2'd0,
    CfgPartialTimeout = 2'd1
  } sfd_cfg_e;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdTick = 1'b1
  } sfd_cmd_e;

  typedef enum logic [6:0] {
    PhHunt   = 7'b0000001,
    PhGot80  = 7'b0000010,
    PhSource = 7'b0000100,
    PhId     = 7'b0001000,
    PhLength = 7'b0010000,
    PhData   = 7'b0100000,
    PhCheck  = 7'b1000000
  } sfd_phase_e;

  // one queue entry; dbl means a held 0x80 goes out ahead of data
  typedef struct packed {
    logic       dbl;
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       abort;
    logic       link;
  } sfd_entry_t;

  typedef struct packed {
    logic       push;
    sfd_entry_t entry;
  } sfd_push_t;

  typedef struct packed {
    logic       valid;
    sfd_entry_t entry;
  } sfd_head_t;

  function automatic logic [7:0] hello_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h45;
      4'd1:    c = 8'h53;
      4'd2:    c = 8'h50;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h32;
      4'd5:    c = 8'h2d;
      4'd6:    c = 8'h68;
      4'd7:    c = 8'h65;
      4'd8:    c = 8'h6c;
      4'd9:    c = 8'h6c;
      4'd10:   c = 8'h6f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

endpackage

// ===== rtl/core/sfd_in_if.sv =====
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

// ===== rtl/core/sfd_out_if.sv =====
interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_first;
  logic       out_last;
  logic       out_abort;
  logic       link_up;

  modport source (output valid, out_valid, out_byte, out_first, out_last, out_abort, link_up,
                  input ready);
  modport sink (input valid, out_valid, out_byte, out_first, out_last, out_abort, link_up,
                output ready);
endinterface

// ===== rtl/core/sfd_front.sv =====
module sfd_front import sfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sfd_in_if.sink              in_ch,
  input  logic                full_i,
  output sfd_push_t           push_o
);

  logic [15:0] hto_q, pto_q;
  sfd_phase_e  phase_q, phase_d;
  logic [7:0]  bl_q, bl_d;
  logic [3:0]  hp_q, hp_d;
  logic        link_q, link_d;
  logic [15:0] ha_q, ha_d;
  logic [15:0] pa_q, pa_d;
  sfd_entry_t  ent;
  logic        accept;
  logic [7:0]  b;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && !full_i;
  assign b           = in_ch.rx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hto_q <= HelloTimeoutRst;
      pto_q <= PartialTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (sfd_cfg_e'(cfg_idx_i))
        CfgHelloTimeout:   hto_q <= cfg_data_i;
        CfgPartialTimeout: pto_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    bl_d    = bl_q;
    hp_d    = hp_q;
    link_d  = link_q;
    ha_d    = ha_q;
    pa_d    = pa_q;
    ent     = '0;
    if (in_ch.command == CmdTick) begin
      ha_d = sat_inc16(ha_q);
      if (link_q && ha_d > hto_q) link_d = 1'b0;
      if (phase_q != PhHunt) begin
        pa_d = sat_inc16(pa_q);
        if (pa_d > pto_q) begin
          // only frames already partly sent report an abort
          ent.abort = (phase_q != PhGot80);
          phase_d   = PhHunt;
          bl_d      = 8'd0;
          pa_d      = 16'd0;
        end
      end
    end else begin
      if (hp_q < HelloLen && b == hello_char(hp_q)) begin
        hp_d = hp_q + 4'd1;
      end else begin
        hp_d = (b == hello_char(4'd0)) ? 4'd1 : 4'd0;
      end
      if (hp_d >= HelloLen) begin
        link_d = 1'b1;
        ha_d   = 16'd0;
        hp_d   = 4'd0;
      end
      unique case (phase_q)
        PhHunt: begin
          if (b == HeaderB0) begin
            phase_d = PhGot80;
            pa_d    = 16'd0;
          end
        end
        PhGot80: begin
          if (b == HeaderB1) begin
            phase_d   = PhSource;
            ent.dbl   = 1'b1;
            ent.valid = 1'b1;
            ent.data  = b;
          end else begin
            pa_d = 16'd0;
            if (b != HeaderB0) phase_d = PhHunt;
          end
        end
        PhSource: begin
          phase_d   = PhId;
          ent.valid = 1'b1;
          ent.data  = b;
        end
        PhId: begin
          phase_d   = PhLength;
          ent.valid = 1'b1;
          ent.data  = b;
        end
        PhLength: begin
          bl_d      = b;
          phase_d   = (b == 8'd0) ? PhCheck : PhData;
          ent.valid = 1'b1;
          ent.data  = b;
        end
        PhData: begin
          if (bl_q != 8'd0) bl_d = bl_q - 8'd1;
          if (bl_d == 8'd0) phase_d = PhCheck;
          ent.valid = 1'b1;
          ent.data  = b;
        end
        PhCheck: begin
          phase_d   = PhHunt;
          bl_d      = 8'd0;
          pa_d      = 16'd0;
          ent.valid = 1'b1;
          ent.data  = b;
          ent.last  = 1'b1;
        end
        default: phase_d = PhHunt;
      endcase
    end
    ent.link = link_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      bl_q    <= 8'd0;
      hp_q    <= 4'd0;
      link_q  <= 1'b0;
      ha_q    <= 16'd0;
      pa_q    <= 16'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      bl_q    <= bl_d;
      hp_q    <= hp_d;
      link_q  <= link_d;
      ha_q    <= ha_d;
      pa_q    <= pa_d;
    end
  end

  assign push_o.push  = accept;
  assign push_o.entry = ent;

endmodule

// ===== rtl/core/sfd_fifo.sv =====
module sfd_fifo import sfd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sfd_push_t push_i,
  input  logic      pop_i,
  output logic      full_o,
  output sfd_head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sfd_entry_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.push) mem_q[wr_q] <= push_i.entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (push_i.push && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i.push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/sfd_back.sv =====
module sfd_back import sfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sfd_head_t head_i,
  output logic      pop_o,
  sfd_out_if.source out_ch
);

  logic half_q;
  logic lead;
  logic xfer;

  // a header pair sends the held 0x80 first, then the entry's own byte
  assign lead = head_i.entry.dbl && !half_q;
  assign xfer = head_i.valid && out_ch.ready;
  assign pop_o = xfer && !lead;

  assign out_ch.valid     = head_i.valid;
  assign out_ch.out_valid = lead ? 1'b1 : head_i.entry.valid;
  assign out_ch.out_byte  = lead ? HeaderB0 : head_i.entry.data;
  assign out_ch.out_first = lead;
  assign out_ch.out_last  = lead ? 1'b0 : head_i.entry.last;
  assign out_ch.out_abort = lead ? 1'b0 : head_i.entry.abort;
  assign out_ch.link_up   = head_i.entry.link;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
    end else if (xfer) begin
      half_q <= lead;
    end
  end

endmodule

// ===== rtl/core/serial_frame_deframer_with_link_watch.sv =====
// path: an item's result is written into the result queue and offered from the queue's head
// throughput: one item per cycle while the queue (QueueDepth entries) has room
// a completed header pair gives two results from one queue entry, which is popped after the second
// reset: hunting for header, link down, ages zero, queue empty,
// hello timeout 5000 and partial timeout 100 ticks
module serial_frame_deframer_with_link_watch import sfd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sfd_in_if.sink              in_ch_i,
  sfd_out_if.source           out_ch_o
);

  sfd_push_t push;
  sfd_head_t head;
  logic      full;
  logic      pop;

  sfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch_i),
    .full_i     (full),
    .push_o     (push)
  );

  sfd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  sfd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_ch (out_ch_o)
  );

endmodule

// ===== rtl/core/sfd_checker.sv =====
module sfd_checker import sfd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic       out_valid_i,
  input logic [7:0] out_byte_i,
  input logic       out_first_i,
  input logic       out_last_i,
  input logic       out_abort_i
);

  logic xfer;
  assign xfer = valid_i && ready_i;

  a_first_is_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && out_first_i |-> out_valid_i && out_byte_i == HeaderB0 && !out_last_i && !out_abort_i)
    else $error("first mark on a non-header result");

  a_header_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && out_first_i |=> valid_i && out_valid_i && !out_first_i)
    else $error("header byte not followed by its second byte");

  a_abort_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && out_abort_i |-> !out_valid_i && !out_last_i)
    else $error("abort carries a frame byte");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !out_valid_i |-> out_byte_i == 8'h00 && !out_first_i && !out_last_i)
    else $error("empty result carries frame fields");

endmodule

bind serial_frame_deframer_with_link_watch sfd_checker u_sfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (out_ch_o.valid),
  .ready_i     (out_ch_o.ready),
  .out_valid_i (out_ch_o.out_valid),
  .out_byte_i  (out_ch_o.out_byte),
  .out_first_i (out_ch_o.out_first),
  .out_last_i  (out_ch_o.out_last),
  .out_abort_i (out_ch_o.out_abort)
);
